// ----- sv/bilinear_image_resampler_macros.svh -----
// ----------------------------------------------------------------------------
// Bilinear image resampler assertion macros
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_RESAMPLER_MACROS_SVH
`define BILINEAR_IMAGE_RESAMPLER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BIR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bilinear resampler check failed");

// Consequent checked in the cycle after the antecedent.
`define BIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bilinear resampler check failed");

`endif

// ----- sv/bir_pkg.sv -----
// ----------------------------------------------------------------------------
// bir_pkg
// Widths, codes, types and helper functions of the bilinear image resampler.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int MAX_W   = 512;
  localparam int MAX_H   = 128;

  localparam int CW      = 12;
  localparam int PIX_W   = 8;
  localparam int SCALE_W = 24;
  localparam int SW_W    = 10;
  localparam int SH_W    = 8;
  localparam int CFG_W   = 24;
  localparam int CFG_AW  = 2;

  localparam int XW      = $clog2(MAX_W);
  localparam int YW      = $clog2(MAX_H);
  localparam int DEPTH   = MAX_W * MAX_H;
  localparam int AW      = $clog2(DEPTH);
  localparam int NW      = CW + 1;

  localparam int PROD_W  = CW + 1 + SCALE_W;
  localparam int POS_W   = PROD_W + 1;
  localparam int FRAC_W  = 17;
  localparam int FL_W    = POS_W - FRAC_W + 1;
  localparam int HALF    = 1 << (FRAC_W - 1);
  localparam int WT_W    = 11;
  localparam int WONE_W  = WT_W + 1;
  localparam int WONE    = 1 << WT_W;
  localparam int WP_W    = 2 * WT_W + 1;
  localparam int ACC_W   = PIX_W + WP_W;
  localparam int RND     = 1 << (2 * WT_W - 1);
  localparam int RES_W   = ACC_W - 2 * WT_W;
  localparam int PIX_MAX = (1 << PIX_W) - 1;

  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 32;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_SCALE_X    = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_SCALE_Y    = 2'd3;

  // neighbour code: bit 0 selects the right column, bit 1 the lower row
  localparam logic [1:0] NB_TL = 2'd0;
  localparam logic [1:0] NB_TR = 2'd1;
  localparam logic [1:0] NB_BL = 2'd2;
  localparam logic [1:0] NB_BR = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       mem_wr;
    logic       map_en;
    logic       rd_en;
    logic [1:0] nb;
    logic       acc_en;
    logic       acc_first;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic wr_ok;
  } status_t;

  function automatic logic [NW-1:0] size_in_use(input logic [CFG_W-1:0] v, input int cap);
    logic [NW-1:0] r;
    if (v == '0) begin
      r = NW'(1);
    end else if (v > cap) begin
      r = NW'(cap);
    end else begin
      r = v[NW-1:0];
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_idx(input logic signed [FL_W-1:0] v,
                                              input logic [NW-1:0] n);
    logic [NW-1:0] lim;
    logic [CW-1:0] r;
    lim = n - NW'(1);
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(FL_W-NW){1'b0}}, lim})) begin
      r = lim[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/bilinear_image_resampler.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_resampler
// Frame store with half-pixel-centered bilinear resampling of 8-bit pixels.
// ----------------------------------------------------------------------------
// A write transaction (in_tuser low) stores one source pixel in a single-port
// frame memory of 512 x 128 pixels; writes stream at one per clock while no
// sample is in progress, and writes outside the configured image are dropped.
// A sample transaction (in_tuser high) is worked through before the next
// transaction can be accepted: its acceptance cycle forms (2d+1)*scale, then
// the sequencer floors, clamps and weights both axes, reads the four
// neighbours through the one memory port, and finishes the blend and loads
// the result register. in_tready stays low after a sample is accepted until
// the sequencer is idle again; out_tvalid rises with that load. The result
// register frees the input side: a new transaction is taken while a result
// waits for out_tready; a sample that finishes while an earlier result still
// waits holds in its last cycle, with in_tready low, until out_tready takes
// that result. The frame memory needs no clearing after reset; pixels must
// be written before they are sampled. Configure only while idle.
module bilinear_image_resampler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bir_pkg::IN_DW-1:0]  in_tdata,   // col[11:0], row[23:12], pixel_in[31:24]
  input  logic                       in_tuser,   // func[0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bir_pkg::OUT_DW-1:0] out_tdata,  // pixel_out[7:0], dst_col[19:8], dst_row[31:20]
  input  logic                       cfg_wr_en,
  input  logic [bir_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bir_pkg::CFG_W-1:0]  cfg_wdata
);

  bir_pkg::cmd_t    cmd;
  bir_pkg::status_t st;

  bir_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  bir_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- sv/bir_ram.sv -----
// ----------------------------------------------------------------------------
// bir_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/bir_ctrl.sv -----
// ----------------------------------------------------------------------------
// bir_ctrl
// Sequencer: accepts transactions, steps a sample through mapping, four
// frame reads and accumulation, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bir_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  bir_pkg::status_t st,
  output bir_pkg::cmd_t    cmd
);

  bir_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bir_pkg::ST_IDLE: begin
        if (in_tvalid && st.is_sample) begin
          state_nxt = bir_pkg::ST_MAP;
        end
      end
      bir_pkg::ST_MAP: state_nxt = bir_pkg::ST_RD0;
      bir_pkg::ST_RD0: state_nxt = bir_pkg::ST_RD1;
      bir_pkg::ST_RD1: state_nxt = bir_pkg::ST_RD2;
      bir_pkg::ST_RD2: state_nxt = bir_pkg::ST_RD3;
      bir_pkg::ST_RD3: state_nxt = bir_pkg::ST_ACC;
      bir_pkg::ST_ACC: state_nxt = bir_pkg::ST_DONE;
      bir_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bir_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bir_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        cmd.mem_wr = in_tvalid && !st.is_sample && st.wr_ok;
      end
      bir_pkg::ST_MAP: cmd.map_en = 1'b1;
      bir_pkg::ST_RD0: begin
        cmd.rd_en = 1'b1;
        cmd.nb    = bir_pkg::NB_TL;
      end
      bir_pkg::ST_RD1: begin
        cmd.rd_en     = 1'b1;
        cmd.nb        = bir_pkg::NB_TR;
        cmd.acc_en    = 1'b1;
        cmd.acc_first = 1'b1;
      end
      bir_pkg::ST_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.nb     = bir_pkg::NB_BL;
        cmd.acc_en = 1'b1;
      end
      bir_pkg::ST_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.nb     = bir_pkg::NB_BR;
        cmd.acc_en = 1'b1;
      end
      bir_pkg::ST_ACC: cmd.acc_en = 1'b1;
      bir_pkg::ST_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bir_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- sv/bir_dp.sv -----
// ----------------------------------------------------------------------------
// bir_dp
// Datapath: configuration registers, coordinate mapping, frame store,
// weight products, blend accumulator and result register.
// ----------------------------------------------------------------------------
module bir_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bir_pkg::IN_DW-1:0]  in_tdata,
  input  logic                       in_tuser,
  output logic [bir_pkg::OUT_DW-1:0] out_tdata,
  input  logic                       cfg_wr_en,
  input  logic [bir_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bir_pkg::CFG_W-1:0]  cfg_wdata,
  input  bir_pkg::cmd_t              cmd,
  output bir_pkg::status_t           st
);

  logic [bir_pkg::SW_W-1:0]    src_width_r;
  logic [bir_pkg::SH_W-1:0]    src_height_r;
  logic [bir_pkg::SCALE_W-1:0] scale_x_r;
  logic [bir_pkg::SCALE_W-1:0] scale_y_r;

  logic [bir_pkg::NW-1:0]      w_use, h_use;
  logic [bir_pkg::CW-1:0]      in_col, in_row;
  logic [bir_pkg::PIX_W-1:0]   in_pix;
  logic [bir_pkg::AW-1:0]      wr_addr, rd_addr, mem_addr;
  logic [bir_pkg::PIX_W-1:0]   mem_rdata;

  logic [bir_pkg::CW-1:0]      col_r, row_r;
  logic [bir_pkg::PROD_W-1:0]  prodx_r, prody_r;

  logic signed [bir_pkg::POS_W-1:0] posx, posy;
  logic signed [bir_pkg::FL_W-1:0]  flx, fly, flx1, fly1;
  logic [bir_pkg::CW-1:0]      cx0, cx1, cy0, cy1;

  logic [bir_pkg::XW-1:0]      x0_r, x1_r;
  logic [bir_pkg::YW-1:0]      y0_r, y1_r;
  logic [bir_pkg::WT_W-1:0]    wx_r, wy_r;

  logic [bir_pkg::XW-1:0]      sel_x;
  logic [bir_pkg::YW-1:0]      sel_y;
  logic [bir_pkg::WONE_W-1:0]  wxa, wyb;
  logic [2*bir_pkg::WONE_W-1:0] wp_full;
  logic [bir_pkg::WP_W-1:0]    wp_r;

  logic [bir_pkg::ACC_W-1:0]   term, acc_r, acc_nxt, rnd;
  logic [bir_pkg::RES_W-1:0]   res;
  logic [bir_pkg::PIX_W-1:0]   pix_sat;

  logic [bir_pkg::PIX_W-1:0]   pixel_out_r;
  logic [bir_pkg::CW-1:0]      dst_col_r, dst_row_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bir_pkg::SW_W'(1);
      src_height_r <= bir_pkg::SH_W'(1);
      scale_x_r    <= bir_pkg::SCALE_W'(65536);
      scale_y_r    <= bir_pkg::SCALE_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bir_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[bir_pkg::SW_W-1:0];
        bir_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[bir_pkg::SH_W-1:0];
        bir_pkg::CFG_SCALE_X:    scale_x_r    <= cfg_wdata[bir_pkg::SCALE_W-1:0];
        bir_pkg::CFG_SCALE_Y:    scale_y_r    <= cfg_wdata[bir_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_use = bir_pkg::size_in_use(bir_pkg::CFG_W'(src_width_r), bir_pkg::MAX_W);
  assign h_use = bir_pkg::size_in_use(bir_pkg::CFG_W'(src_height_r), bir_pkg::MAX_H);

  assign in_col = in_tdata[bir_pkg::CW-1:0];
  assign in_row = in_tdata[2*bir_pkg::CW-1:bir_pkg::CW];
  assign in_pix = in_tdata[2*bir_pkg::CW+bir_pkg::PIX_W-1:2*bir_pkg::CW];

  assign st.is_sample = (in_tuser == bir_pkg::FUNC_SAMPLE);
  assign st.wr_ok     = (32'(in_col) < 32'(w_use)) && (32'(in_row) < 32'(h_use));

  // accept: latch request and form (2d+1)*scale
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col_r   <= in_col;
      row_r   <= in_row;
      prodx_r <= bir_pkg::PROD_W'({in_col, 1'b1}) * bir_pkg::PROD_W'(scale_x_r);
      prody_r <= bir_pkg::PROD_W'({in_row, 1'b1}) * bir_pkg::PROD_W'(scale_y_r);
    end
  end

  // map: floor, clamp and weight per axis
  assign posx = $signed({1'b0, prodx_r}) - $signed(bir_pkg::POS_W'(bir_pkg::HALF));
  assign posy = $signed({1'b0, prody_r}) - $signed(bir_pkg::POS_W'(bir_pkg::HALF));
  assign flx  = bir_pkg::FL_W'(posx >>> bir_pkg::FRAC_W);
  assign fly  = bir_pkg::FL_W'(posy >>> bir_pkg::FRAC_W);
  assign flx1 = flx + bir_pkg::FL_W'(1);
  assign fly1 = fly + bir_pkg::FL_W'(1);
  assign cx0  = bir_pkg::clamp_idx(flx, w_use);
  assign cx1  = bir_pkg::clamp_idx(flx1, w_use);
  assign cy0  = bir_pkg::clamp_idx(fly, h_use);
  assign cy1  = bir_pkg::clamp_idx(fly1, h_use);

  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      x0_r <= cx0[bir_pkg::XW-1:0];
      x1_r <= cx1[bir_pkg::XW-1:0];
      y0_r <= cy0[bir_pkg::YW-1:0];
      y1_r <= cy1[bir_pkg::YW-1:0];
      wx_r <= posx[bir_pkg::FRAC_W-1:bir_pkg::FRAC_W-bir_pkg::WT_W];
      wy_r <= posy[bir_pkg::FRAC_W-1:bir_pkg::FRAC_W-bir_pkg::WT_W];
    end
  end

  // neighbour read and its weight product
  assign sel_x = cmd.nb[0] ? x1_r : x0_r;
  assign sel_y = cmd.nb[1] ? y1_r : y0_r;
  assign wxa   = cmd.nb[0] ? bir_pkg::WONE_W'(wx_r)
                           : bir_pkg::WONE_W'(bir_pkg::WONE) - bir_pkg::WONE_W'(wx_r);
  assign wyb   = cmd.nb[1] ? bir_pkg::WONE_W'(wy_r)
                           : bir_pkg::WONE_W'(bir_pkg::WONE) - bir_pkg::WONE_W'(wy_r);
  assign wp_full = (2*bir_pkg::WONE_W)'(wxa) * (2*bir_pkg::WONE_W)'(wyb);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      wp_r <= wp_full[bir_pkg::WP_W-1:0];
    end
  end

  assign wr_addr  = bir_pkg::AW'(32'(in_row) * bir_pkg::MAX_W + 32'(in_col));
  assign rd_addr  = bir_pkg::AW'(32'(sel_y) * bir_pkg::MAX_W + 32'(sel_x));
  assign mem_addr = cmd.mem_wr ? wr_addr : rd_addr;

  bir_ram #(
    .WIDTH (bir_pkg::PIX_W),
    .DEPTH (bir_pkg::DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .addr  (mem_addr),
    .wdata (in_pix),
    .rdata (mem_rdata)
  );

  // blend accumulate
  assign term    = bir_pkg::ACC_W'(mem_rdata) * bir_pkg::ACC_W'(wp_r);
  assign acc_nxt = (cmd.acc_first ? '0 : acc_r) + term;

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // round half up and saturate
  assign rnd     = acc_r + bir_pkg::ACC_W'(bir_pkg::RND);
  assign res     = rnd[bir_pkg::ACC_W-1:2*bir_pkg::WT_W];
  assign pix_sat = (32'(res) > bir_pkg::PIX_MAX) ? bir_pkg::PIX_W'(bir_pkg::PIX_MAX)
                                                 : res[bir_pkg::PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out_r <= pix_sat;
      dst_col_r   <= col_r;
      dst_row_r   <= row_r;
    end
  end

  assign out_tdata = {dst_row_r, dst_col_r, pixel_out_r};

endmodule

// ----- sv/bir_checker.sv -----
// ----------------------------------------------------------------------------
// bir_checker
// Port-level checks of the bilinear image resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "bilinear_image_resampler_macros.svh"

module bir_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [bir_pkg::OUT_DW-1:0] out_tdata
);

  logic wr_xact, smp_xact;

  assign wr_xact  = in_tvalid && in_tready && (in_tuser == bir_pkg::FUNC_WRITE);
  assign smp_xact = in_tvalid && in_tready && (in_tuser == bir_pkg::FUNC_SAMPLE);

  // hold a stalled result
  `BIR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a write leaves the input open
  `BIR_ASSERT_NEXT(a_write_one_cycle, wr_xact, in_tready)

  // a sample closes the input while it is worked
  `BIR_ASSERT_NEXT(a_sample_busy, smp_xact, !in_tready)

  // a new result follows a busy cycle
  `BIR_ASSERT_NOW(a_result_after_work, $rose(out_tvalid), !$past(in_tready))

endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (.*);
